### hdl/ibl_pkg.sv
// ibl_pkg: shared types and constants for the insertable byte list
// operation codes, status codes and the control word broadcast to the cells
// no dependencies
package ibl_pkg;

  localparam int DATA_W = 8;   // width of one stored byte
  localparam int CNT_W  = 7;   // width of the element count and of cell indexes
  localparam int POS_W  = 8;   // width of the signed position field
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_INSERT     = 3'd4,
    KIND_SET        = 3'd5,
    KIND_GET        = 3'd6
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // the operation that every cell carries out
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,  // keep own byte
    CELL_OPEN  = 2'd1,  // open a gap at index 'at', later cells take left neighbor
    CELL_SHIFT = 2'd2,  // every cell takes its right neighbor
    CELL_WRITE = 2'd3   // overwrite the cell at index 'at'
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [CNT_W-1:0]    at;
    logic [DATA_W-1:0]   value;
  } cell_ctrl_t;

endpackage

### hdl/ibl_cell.sv
// ibl_cell: one storage cell of the list chain
// holds one byte and trades it with its two neighbors; uses ibl_pkg
module ibl_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  ibl_pkg::cell_ctrl_t       ctrl,
  input  logic [ibl_pkg::DATA_W-1:0] left_i,
  input  logic [ibl_pkg::DATA_W-1:0] right_i,
  output logic [ibl_pkg::DATA_W-1:0] value_o
);
  import ibl_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    case (ctrl.op)
      CELL_OPEN: begin
        if (MY_IDX == ctrl.at) begin
          value_nxt = ctrl.value;
        end else if (MY_IDX > ctrl.at) begin
          value_nxt = left_i;
        end
      end
      CELL_SHIFT: value_nxt = right_i;
      CELL_WRITE: begin
        if (MY_IDX == ctrl.at) begin
          value_nxt = ctrl.value;
        end
      end
      default: value_nxt = value_r;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o = value_r;

endmodule

### hdl/ibl_read_gather.sv
// ibl_read_gather: two-level registered or-tree that picks one cell for a get
// first level captures groups of eight masked cells; uses ibl_pkg
module ibl_read_gather #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       cap,
  input  logic                       rd_en,
  input  logic [ibl_pkg::CNT_W-1:0]  sel,
  input  logic [ibl_pkg::DATA_W-1:0] cell_q [DEPTH],
  output logic [ibl_pkg::DATA_W-1:0] rd_value
);
  import ibl_pkg::*;

  localparam int GRP  = 8;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  logic [DATA_W-1:0] part_r   [NGRP];
  logic [DATA_W-1:0] part_nxt [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part_nxt[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if ((g * GRP + j) < DEPTH) begin
          if (rd_en && (sel == CNT_W'(g * GRP + j))) begin
            part_nxt[g] = part_nxt[g] | cell_q[g * GRP + j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      for (int g = 0; g < NGRP; g++) begin
        part_r[g] <= part_nxt[g];
      end
    end
  end

  always_comb begin
    rd_value = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_value = rd_value | part_r[g];
    end
  end

endmodule

### hdl/insertable_byte_list.sv
// insertable_byte_list: fixed-capacity ordered byte list built as a chain of cells
// pipeline: two register stages, stage one and then the output register that drives out_valid
// throughput: one transaction per cycle; the only stall is out_stall backing up
// reset clears the element count and both pipeline valids; cell bytes are not
// cleared, only cells below the count are ever read
// depends on ibl_pkg, ibl_cell, ibl_read_gather
module insertable_byte_list #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ibl_pkg::KIND_W-1:0] in_kind,
  input  logic [ibl_pkg::DATA_W-1:0] in_value,
  input  logic signed [ibl_pkg::POS_W-1:0] in_position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ibl_pkg::DATA_W-1:0] out_read_value,
  output logic [ibl_pkg::STAT_W-1:0] out_status,
  output logic [ibl_pkg::CNT_W-1:0]  out_count
);
  import ibl_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // list state
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [DATA_W-1:0] cell_q [DEPTH];

  // first stage: status and count of the accepted transaction, read tree captured
  logic              s1_valid_r;
  logic [STAT_W-1:0] s1_status_r;
  logic [CNT_W-1:0]  s1_count_r;

  // output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_read_value_r;
  logic [STAT_W-1:0] out_status_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              in_fire;
  logic              s1_move;
  logic [DATA_W-1:0] rd_value;

  // decode
  cell_ctrl_t        ctrl;
  cell_ctrl_t        ctrl_dec;
  status_t           status_dec;
  logic              rd_en;
  logic              full;
  logic              empty;
  logic              pos_neg;
  logic [CNT_W-1:0]  pos_u;
  logic              pos_ins_ok;
  logic              pos_acc_ok;

  // handshake: stage one advances when the output register is free or draining
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_fire  = in_valid && !in_stall;

  // position checks, negative positions are always out of range
  assign full       = (count_r == DEPTH_C);
  assign empty      = (count_r == '0);
  assign pos_neg    = in_position[POS_W-1];
  assign pos_u      = in_position[CNT_W-1:0];
  assign pos_ins_ok = !pos_neg && (pos_u <= count_r);
  assign pos_acc_ok = !pos_neg && (pos_u < count_r);

  always_comb begin
    ctrl_dec.op    = CELL_HOLD;
    ctrl_dec.at    = '0;
    ctrl_dec.value = in_value;
    status_dec     = ST_OK;
    count_nxt      = count_r;
    rd_en          = 1'b0;
    case (kind_t'(in_kind))
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_dec = ST_FULL;
        end else begin
          ctrl_dec.op = CELL_OPEN;
          ctrl_dec.at = '0;
          count_nxt   = count_r + 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          status_dec = ST_FULL;
        end else begin
          ctrl_dec.op = CELL_OPEN;
          ctrl_dec.at = count_r;
          count_nxt   = count_r + 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_dec = ST_EMPTY;
        end else begin
          ctrl_dec.op = CELL_SHIFT;
          count_nxt   = count_r - 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          status_dec = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      KIND_INSERT: begin
        // out-of-range insert appends at the back
        if (full) begin
          status_dec = ST_FULL;
        end else begin
          ctrl_dec.op = CELL_OPEN;
          ctrl_dec.at = pos_ins_ok ? pos_u : count_r;
          count_nxt   = count_r + 1'b1;
        end
      end
      KIND_SET: begin
        if (pos_acc_ok) begin
          ctrl_dec.op = CELL_WRITE;
          ctrl_dec.at = pos_u;
        end else begin
          status_dec = ST_BADPOS;
        end
      end
      KIND_GET: begin
        if (pos_acc_ok) begin
          rd_en = 1'b1;
        end else begin
          status_dec = ST_BADPOS;
        end
      end
      default: begin
        // unused kind leaves the list alone
        status_dec = ST_OK;
      end
    endcase
  end

  // cells only move on an accepted transaction
  always_comb begin
    ctrl = ctrl_dec;
    if (!in_fire) begin
      ctrl.op = CELL_HOLD;
    end
  end

  // the chain: cell 0 has no left neighbor, the last cell feeds itself on a shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = cell_q[i];
    end else begin : g_mid_r
      assign right_v = cell_q[i+1];
    end
    ibl_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (cell_q[i])
    );
  end

  // get reads the cells as they stand before this transaction's update,
  // which is the same thing since a get never writes
  ibl_read_gather #(
    .DEPTH (DEPTH)
  ) u_gather (
    .clk      (clk),
    .cap      (in_fire),
    .rd_en    (rd_en),
    .sel      (pos_u),
    .cell_q   (cell_q),
    .rd_value (rd_value)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= status_dec;
      s1_count_r  <= count_nxt;
    end
    if (s1_move) begin
      out_read_value_r <= rd_value;
      out_status_r     <= s1_status_r;
      out_count_r      <= s1_count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

  // count never goes past capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("element count above capacity");

  // a failed transaction reads zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_read_value_r == '0))
    else $error("failed transaction returned nonzero read value");

  // an empty report means the list really is empty
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_EMPTY)) |-> (out_count_r == '0))
    else $error("empty status with nonzero count");

  // a push or insert into a full list leaves the count alone
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (status_dec == ST_FULL)) |=> (count_r == $past(count_r)))
    else $error("count changed on a dropped push");

  // a stage-one transaction waiting means the input is held off
  a_s1_block: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input accepted while pipeline blocked");

endmodule
